// ===== design/fsbsg_pkg.sv =====
// Package for the boot sector geometry decoder: payload structs, status codes,
// constants and the size-code decode function. No dependencies.
package fsbsg_pkg;

    localparam logic [63:0] SIG_VALUE     = 64'h2020_2020_5346_544E;
    localparam int          CLUS_EXP_MAX  = 12;
    localparam int          CLUS_LOG_MAX  = 21;   // 2 MiB
    localparam int          SIZE_EXP_LIM  = 32;
    localparam int          CODE_HALF     = 128;
    localparam int          CODE_MAX      = 255;
    localparam int          SECT_LOG_MIN  = 8;    // 256 bytes
    localparam int          SECT_LOG_MAX  = 12;   // 4096 bytes

    localparam logic [12:0] MIN_REC_RST   = 13'd48;
    localparam logic [31:0] MAX_REC_RST   = 32'd134217728;
    localparam logic [12:0] MIN_IDX_RST   = 13'd24;

    typedef enum logic [1:0] {
        CFG_MIN_REC = 2'd0,
        CFG_MAX_REC = 2'd1,
        CFG_MIN_IDX = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SIGNATURE = 4'd1,
        ST_SECTOR    = 4'd2,
        ST_CLUS_EXP  = 4'd3,
        ST_CLUS_SIZE = 4'd4,
        ST_REC_CODE  = 4'd5,
        ST_REC_OVF   = 4'd6,
        ST_REC_BOUND = 4'd7,
        ST_IDX_CODE  = 4'd8,
        ST_IDX_OVF   = 4'd9,
        ST_IDX_SMALL = 4'd10,
        ST_VOL_OVF   = 4'd11
    } status_t;

    typedef struct packed {
        logic [63:0] signature;
        logic [15:0] sector_bytes;
        logic [7:0]  cluster_code;
        logic [63:0] total_sectors;
        logic [63:0] table_cluster;
        logic [63:0] mirror_cluster;
        logic [31:0] record_code;
        logic [31:0] index_code;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [21:0] cluster_size;
        logic [31:0] record_size;
        logic [31:0] index_size;
        logic [63:0] volume_bytes;
        logic [63:0] table_offset;
        logic [63:0] mirror_offset;
    } out_item_t;

    typedef struct packed {
        logic        bad_code;
        logic        ovf;
        logic [31:0] size;
    } size_dec_t;

    // Cluster size is 2^ce with ce <= 21, so a code below 128 can never overflow 32 bits.
    function automatic size_dec_t decode_size(input logic [31:0] code, input logic [4:0] ce);
        size_dec_t  r;
        logic [8:0] e;
        r.bad_code = (code == 32'd0) || (code > 32'(CODE_MAX));
        r.ovf      = 1'b0;
        r.size     = 32'd0;
        e          = 9'd256 - {1'b0, code[7:0]};
        if (code[7] == 1'b0) begin
            r.size = {25'd0, code[6:0]} << ce;
        end else if (e >= 9'(SIZE_EXP_LIM)) begin
            r.ovf = 1'b1;
        end else begin
            r.size = 32'd1 << e[4:0];
        end
        return r;
    endfunction

endpackage

// ===== design/fs_boot_sector_geometry_decode.sv =====
// Boot sector geometry decoder, top level: three-stage pipeline.
// Depends on fsbsg_pkg.

// Checks and decodes one set of raw boot-sector fields per transaction and
// returns one result per transaction, in order. Throughput is one transaction
// per clock while no result waits on m_ready; each transaction passes through
// three register stages (field checks and cluster exponent, size decode and
// barrel shifts, bound compares and status selection). The whole pipeline
// holds while a result waits on m_ready. Configuration registers are written
// through cfg_wen/cfg_index/cfg_data and must only change while no
// transaction is in flight.
module fs_boot_sector_geometry_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fsbsg_pkg::in_item_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fsbsg_pkg::out_item_t m_data,
    input  logic                cfg_wen,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import fsbsg_pkg::*;

    typedef struct packed {
        logic        sig_ok;
        logic        sec_ok;
        logic        cexp_bad;
        logic        clus_ok;
        logic [3:0]  sb;
        logic [4:0]  ce;
        logic [63:0] total;
        logic [63:0] tcl;
        logic [63:0] mcl;
        logic [31:0] rcode;
        logic [31:0] icode;
    } st1_t;

    typedef struct packed {
        status_t     pre;
        size_dec_t   rec;
        size_dec_t   idx;
        logic        vol_ovf;
        logic [4:0]  ce;
        logic [63:0] vol;
        logic [63:0] toff;
        logic [63:0] moff;
    } st2_t;

    logic [12:0] min_rec_reg;
    logic [31:0] max_rec_reg;
    logic [12:0] min_idx_reg;

    logic        v1_reg, v2_reg, v3_reg;
    st1_t        s1_reg, s1_next;
    st2_t        s2_reg, s2_next;
    out_item_t   out_reg, out_next;
    logic        adv;

    assign adv     = !v3_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = v3_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_rec_reg <= MIN_REC_RST;
            max_rec_reg <= MAX_REC_RST;
            min_idx_reg <= MIN_IDX_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_MIN_REC: min_rec_reg <= cfg_data[12:0];
                CFG_MAX_REC: max_rec_reg <= cfg_data;
                CFG_MIN_IDX: min_idx_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // stage 1: signature, sector size, cluster exponent
    always_comb begin
        logic [7:0] cc;
        logic [7:0] e;
        logic [3:0] base;
        logic       pow2;
        cc   = s_data.cluster_code;
        e    = 8'(9'd256 - {1'b0, cc});
        base = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (cc[i]) base = 4'(i);
        end
        pow2 = (cc != 8'd0) && ((cc & (cc - 8'd1)) == 8'd0);

        s1_next.sig_ok = (s_data.signature == SIG_VALUE);
        s1_next.sec_ok = 1'b1;
        case (s_data.sector_bytes)
            16'd256:  s1_next.sb = 4'd8;
            16'd512:  s1_next.sb = 4'd9;
            16'd1024: s1_next.sb = 4'd10;
            16'd2048: s1_next.sb = 4'd11;
            16'd4096: s1_next.sb = 4'd12;
            default: begin
                s1_next.sb     = 4'd0;
                s1_next.sec_ok = 1'b0;
            end
        endcase
        s1_next.cexp_bad = 1'b0;
        if (cc > 8'(CODE_HALF)) begin
            s1_next.cexp_bad = (e > 8'(CLUS_EXP_MAX));
            base = e[3:0];
            pow2 = 1'b1;
        end
        s1_next.ce      = 5'(base) + 5'(s1_next.sb);
        s1_next.clus_ok = pow2 && (s1_next.ce <= 5'(CLUS_LOG_MAX));
        s1_next.total   = s_data.total_sectors;
        s1_next.tcl     = s_data.table_cluster;
        s1_next.mcl     = s_data.mirror_cluster;
        s1_next.rcode   = s_data.record_code;
        s1_next.icode   = s_data.index_code;
    end

    // stage 2: size codes, volume bound, shifts
    always_comb begin
        logic [6:0]  shamt;
        logic [63:0] lim;
        shamt = 7'd64 - 7'(s1_reg.sb);
        lim   = 64'd1 << shamt;
        if (!s1_reg.sig_ok)        s2_next.pre = ST_SIGNATURE;
        else if (!s1_reg.sec_ok)   s2_next.pre = ST_SECTOR;
        else if (s1_reg.cexp_bad)  s2_next.pre = ST_CLUS_EXP;
        else if (!s1_reg.clus_ok)  s2_next.pre = ST_CLUS_SIZE;
        else                       s2_next.pre = ST_OK;
        s2_next.rec     = decode_size(s1_reg.rcode, s1_reg.ce);
        s2_next.idx     = decode_size(s1_reg.icode, s1_reg.ce);
        s2_next.vol_ovf = (s1_reg.total > lim);
        s2_next.ce      = s1_reg.ce;
        s2_next.vol     = (s1_reg.total << s1_reg.sb) + (64'd1 << s1_reg.sb);
        s2_next.toff    = s1_reg.tcl << s1_reg.ce;
        s2_next.moff    = s1_reg.mcl << s1_reg.ce;
    end

    // stage 3: bounds and status priority
    always_comb begin
        status_t st;
        if (s2_reg.pre != ST_OK)                               st = s2_reg.pre;
        else if (s2_reg.rec.bad_code)                          st = ST_REC_CODE;
        else if (s2_reg.rec.ovf)                               st = ST_REC_OVF;
        else if (s2_reg.rec.size < {19'd0, min_rec_reg}
                 || s2_reg.rec.size >= max_rec_reg)            st = ST_REC_BOUND;
        else if (s2_reg.idx.bad_code)                          st = ST_IDX_CODE;
        else if (s2_reg.idx.ovf)                               st = ST_IDX_OVF;
        else if (s2_reg.idx.size < {19'd0, min_idx_reg})       st = ST_IDX_SMALL;
        else if (s2_reg.vol_ovf)                               st = ST_VOL_OVF;
        else                                                   st = ST_OK;
        out_next = '0;
        out_next.status = st;
        if (st == ST_OK) begin
            out_next.cluster_size  = 22'd1 << s2_reg.ce;
            out_next.record_size   = s2_reg.rec.size;
            out_next.index_size    = s2_reg.idx.size;
            out_next.volume_bytes  = s2_reg.vol;
            out_next.table_offset  = s2_reg.toff;
            out_next.mirror_offset = s2_reg.moff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            out_reg <= out_next;
        end
    end

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |->
            m_data.cluster_size == 22'd0 && m_data.record_size == 32'd0
            && m_data.index_size == 32'd0 && m_data.volume_bytes == 64'd0)
        else $error("error result carries non-zero fields");

    a_ok_cluster: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_OK |->
            $onehot(m_data.cluster_size) && m_data.cluster_size >= 22'd256)
        else $error("cluster size not a power of two");

    a_ok_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_OK |->
            m_data.record_size < max_rec_reg
            && m_data.record_size >= {19'd0, min_rec_reg}
            && m_data.index_size >= {19'd0, min_idx_reg})
        else $error("accepted sizes outside configured bounds");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && !adv |=> v1_reg && $stable(s1_reg))
        else $error("stage one changed during a stall");

endmodule
